// File: hdl/pclru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pclru_pkg;

    // request codes
    localparam logic [1:0] FUNC_READ      = 2'd0;
    localparam logic [1:0] FUNC_WRITE     = 2'd1;
    localparam logic [1:0] FUNC_FLUSH     = 2'd2;
    localparam logic [1:0] FUNC_FLUSH_INV = 2'd3;

    localparam int TAG_W     = 32;
    localparam int OUT_SLOT_W = 4;
    localparam int IDX_EXT_W = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_APPLY,
        S_WALK,
        S_FLUSH_END
    } t_state;

    typedef struct packed {
        logic load_req;
        logic lookup;
        logic apply;
        logic walk_emit;
        logic walk_step;
        logic flush_end;
    } t_cmd;

    typedef struct packed {
        logic req_flush;
        logic out_free;
        logic walk_dirty;
        logic walk_last;
    } t_sts;

endpackage

`default_nettype wire

// File: hdl/pclru_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pclru_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire pclru_pkg::t_sts i_sts,
    output pclru_pkg::t_cmd    o_cmd
);

    pclru_pkg::t_state r_state;
    pclru_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pclru_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            pclru_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = i_sts.req_flush ? pclru_pkg::S_WALK : pclru_pkg::S_LOOKUP;
                end
            end
            pclru_pkg::S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state = pclru_pkg::S_APPLY;
            end
            pclru_pkg::S_APPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state = pclru_pkg::S_IDLE;
                end
            end
            pclru_pkg::S_WALK: begin
                // hold on a dirty line until the output word can be loaded
                if (!i_sts.walk_dirty || i_sts.out_free) begin
                    o_cmd.walk_emit = i_sts.walk_dirty;
                    o_cmd.walk_step = 1'b1;
                    if (i_sts.walk_last) begin
                        n_state = pclru_pkg::S_FLUSH_END;
                    end
                end
            end
            pclru_pkg::S_FLUSH_END: begin
                if (i_sts.out_free) begin
                    o_cmd.flush_end = 1'b1;
                    n_state = pclru_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pclru_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/pclru_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pclru_dp #(
    parameter int SLOTS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire pclru_pkg::t_cmd                  i_cmd,
    output pclru_pkg::t_sts                       o_sts,
    input  wire logic [1:0]                       i_func,
    input  wire logic [pclru_pkg::TAG_W-1:0]      i_block_index,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic                             i_cfg_wr_data,
    input  wire logic                             i_stall,
    output logic                                  o_valid,
    output logic                                  o_hit,
    output logic [pclru_pkg::OUT_SLOT_W-1:0]      o_slot,
    output logic                                  o_fetch,
    output logic                                  o_direct_write,
    output logic                                  o_writeback,
    output logic [pclru_pkg::TAG_W-1:0]           o_writeback_block,
    output logic                                  o_last
);

    localparam int SW = $clog2(SLOTS);
    localparam int RW = SW + 1;

    // line state
    logic [SLOTS-1:0]             r_valid;
    logic [SLOTS-1:0]             r_dirty;
    logic [pclru_pkg::TAG_W-1:0]  r_tag  [SLOTS];
    logic [SW-1:0]                r_rank [SLOTS];
    logic                         r_policy;

    // request and lookup results
    logic [1:0]                   r_func;
    logic [pclru_pkg::TAG_W-1:0]  r_blk;
    logic [SW-1:0]                r_walk;
    logic [SW-1:0]                r_sel;
    logic [RW-1:0]                r_old_rank;
    logic                         r_hit;
    logic                         r_wb;
    logic [pclru_pkg::TAG_W-1:0]  r_wb_tag;

    // output word
    logic                         r_out_valid;
    logic                         r_o_hit;
    logic [pclru_pkg::OUT_SLOT_W-1:0] r_o_slot;
    logic                         r_o_fetch;
    logic                         r_o_wt;
    logic                         r_o_wb;
    logic [pclru_pkg::TAG_W-1:0]  r_o_wb_blk;
    logic                         r_o_last;

    logic                         any_hit;
    logic                         any_free;
    logic [SW-1:0]                hit_idx;
    logic [SW-1:0]                free_idx;
    logic [SW-1:0]                vic_idx;
    logic [SW-1:0]                sel_idx;
    logic [RW-1:0]                old_rank;
    logic                         is_write;
    logic [pclru_pkg::IDX_EXT_W-1:0] sel_ext;
    logic [pclru_pkg::IDX_EXT_W-1:0] walk_ext;
    logic                         load_out;

    // parallel tag compare, lowest free slot and LRU line
    always_comb begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        vic_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == r_blk)) begin
                any_hit = 1'b1;
                hit_idx = SW'(i);
            end
            if (!r_valid[i]) begin
                any_free = 1'b1;
                free_idx = SW'(i);
            end
            if (r_rank[i] == SW'(SLOTS - 1)) begin
                vic_idx = SW'(i);
            end
        end
        if (any_hit) begin
            sel_idx  = hit_idx;
            old_rank = {1'b0, r_rank[hit_idx]};
        end else if (any_free) begin
            sel_idx  = free_idx;
            old_rank = RW'(SLOTS);
        end else begin
            sel_idx  = vic_idx;
            old_rank = {1'b0, r_rank[vic_idx]};
        end
    end

    assign is_write = (r_func == pclru_pkg::FUNC_WRITE);
    assign sel_ext  = pclru_pkg::IDX_EXT_W'(r_sel);
    assign walk_ext = pclru_pkg::IDX_EXT_W'(r_walk);
    assign load_out = i_cmd.apply | i_cmd.walk_emit | i_cmd.flush_end;

    assign o_sts.req_flush  = (i_func == pclru_pkg::FUNC_FLUSH) ||
                              (i_func == pclru_pkg::FUNC_FLUSH_INV);
    assign o_sts.out_free   = !r_out_valid || !i_stall;
    assign o_sts.walk_dirty = r_valid[r_walk] & r_dirty[r_walk];
    assign o_sts.walk_last  = (r_walk == SW'(SLOTS - 1));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_dirty     <= '0;
            r_policy    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_policy <= i_cfg_wr_data;
            end
            if (i_cmd.apply) begin
                r_valid[r_sel] <= 1'b1;
                if (r_hit) begin
                    if (is_write) begin
                        r_dirty[r_sel] <= r_policy;
                    end
                end else begin
                    r_dirty[r_sel] <= is_write & r_policy;
                end
            end
            if (i_cmd.walk_emit) begin
                r_dirty[r_walk] <= 1'b0;
            end
            if (i_cmd.flush_end && (r_func == pclru_pkg::FUNC_FLUSH_INV)) begin
                r_valid <= '0;
                r_dirty <= '0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_func <= i_func;
            r_blk  <= i_block_index;
            r_walk <= '0;
        end else if (i_cmd.walk_step) begin
            r_walk <= r_walk + 1'b1;
        end
        if (i_cmd.lookup) begin
            r_sel      <= sel_idx;
            r_old_rank <= old_rank;
            r_hit      <= any_hit;
            r_wb       <= !any_hit && !any_free && r_dirty[vic_idx];
            r_wb_tag   <= r_tag[vic_idx];
        end
        if (i_cmd.apply) begin
            // age every valid line that was more recent than the touched one
            for (int i = 0; i < SLOTS; i++) begin
                if (r_valid[i] && (SW'(i) != r_sel) && ({1'b0, r_rank[i]} < r_old_rank)) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
            r_rank[r_sel] <= '0;
            r_tag[r_sel]  <= r_blk;
            r_o_hit    <= r_hit;
            r_o_slot   <= sel_ext[pclru_pkg::OUT_SLOT_W-1:0];
            r_o_fetch  <= !r_hit && !is_write;
            r_o_wt     <= is_write && !r_policy;
            r_o_wb     <= r_wb;
            r_o_wb_blk <= r_wb ? r_wb_tag : '0;
            r_o_last   <= 1'b1;
        end else if (i_cmd.walk_emit) begin
            r_o_hit    <= 1'b0;
            r_o_slot   <= walk_ext[pclru_pkg::OUT_SLOT_W-1:0];
            r_o_fetch  <= 1'b0;
            r_o_wt     <= 1'b0;
            r_o_wb     <= 1'b1;
            r_o_wb_blk <= r_tag[r_walk];
            r_o_last   <= 1'b0;
        end else if (i_cmd.flush_end) begin
            r_o_hit    <= 1'b0;
            r_o_slot   <= '0;
            r_o_fetch  <= 1'b0;
            r_o_wt     <= 1'b0;
            r_o_wb     <= 1'b0;
            r_o_wb_blk <= '0;
            r_o_last   <= 1'b1;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_hit             = r_o_hit;
    assign o_slot            = r_o_slot;
    assign o_fetch           = r_o_fetch;
    assign o_direct_write    = r_o_wt;
    assign o_writeback       = r_o_wb;
    assign o_writeback_block = r_o_wb_blk;
    assign o_last            = r_o_last;

endmodule

`default_nettype wire

// File: hdl/page_cache_lru_controller.sv
// Read or write: after accept, tag compare (LOOKUP), then LRU update and result word load (APPLY);
// a stalled output holds APPLY. Flush: accept, then a walk over every slot with one word per dirty line,
// then the final word; a stalled output holds the walk.
// The next word is accepted once the previous request has loaded its last result.
// Synchronous active-low reset clears valid and dirty bits, policy (write-through)
// and the output valid; tags and ranks are written before use.
`timescale 1ns / 1ps
`default_nettype none

module page_cache_lru_controller #(
    parameter int SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [31:0] i_block_index,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_hit,
    output logic [3:0]       o_slot,
    output logic             o_fetch,
    output logic             o_direct_write,
    output logic             o_writeback,
    output logic [31:0]      o_writeback_block,
    output logic             o_last
);

    pclru_pkg::t_cmd cmd;
    pclru_pkg::t_sts sts;

    pclru_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pclru_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_func            (i_func),
        .i_block_index     (i_block_index),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_hit             (o_hit),
        .o_slot            (o_slot),
        .o_fetch           (o_fetch),
        .o_direct_write    (o_direct_write),
        .o_writeback       (o_writeback),
        .o_writeback_block (o_writeback_block),
        .o_last            (o_last)
    );

endmodule

`default_nettype wire
